@@ hw/rtl/pipc_pkg.sv @@
package pipc_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int COUNT_BITS = 16;

    localparam int S_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((1 + COUNT_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_BITS = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_QUERY_X   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_QUERY_Y   = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RAY_END_X = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RAY_END_Y = CFG_INDEX_BITS'(3);

    localparam logic [COORD_BITS-1:0] RAY_END_RESET = COORD_BITS'(40000);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
        logic signed [COORD_BITS-1:0] ray_end_x;
        logic signed [COORD_BITS-1:0] ray_end_y;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic                         last;
    } edge_t;

    // coordinate differences for the four orientation tests
    typedef struct packed {
        logic signed [DIFF_BITS-1:0] qr_x;
        logic signed [DIFF_BITS-1:0] qr_y;
        logic signed [DIFF_BITS-1:0] qs_x;
        logic signed [DIFF_BITS-1:0] qs_y;
        logic signed [DIFF_BITS-1:0] qe_x;
        logic signed [DIFF_BITS-1:0] qe_y;
        logic signed [DIFF_BITS-1:0] se_x;
        logic signed [DIFF_BITS-1:0] se_y;
        logic signed [DIFF_BITS-1:0] sq_x;
        logic signed [DIFF_BITS-1:0] sq_y;
        logic signed [DIFF_BITS-1:0] sr_x;
        logic signed [DIFF_BITS-1:0] sr_y;
        logic                        box_ok;
        logic                        last;
    } diff_t;

    typedef struct packed {
        logic signed [PROD_BITS-1:0] s_a;
        logic signed [PROD_BITS-1:0] s_b;
        logic signed [PROD_BITS-1:0] e_a;
        logic signed [PROD_BITS-1:0] e_b;
        logic signed [PROD_BITS-1:0] q_a;
        logic signed [PROD_BITS-1:0] q_b;
        logic signed [PROD_BITS-1:0] r_a;
        logic signed [PROD_BITS-1:0] r_b;
        logic                        box_ok;
        logic                        last;
    } prod_t;

    typedef struct packed {
        logic hit;
        logic last;
    } hit_t;

endpackage

@@ hw/rtl/pipc_prep.sv @@
module pipc_prep
    import pipc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  edge_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output diff_t out_item
);

    logic  valid_reg;
    diff_t diff_reg;
    diff_t diff_next;

    // inclusive overlap of [min(a,b), max(a,b)] and [min(c,d), max(c,d)]
    function automatic logic ranges_meet(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b,
        input logic signed [COORD_BITS-1:0] c,
        input logic signed [COORD_BITS-1:0] d
    );
        logic signed [COORD_BITS-1:0] lo1;
        logic signed [COORD_BITS-1:0] hi1;
        logic signed [COORD_BITS-1:0] lo2;
        logic signed [COORD_BITS-1:0] hi2;
        lo1 = (a < b) ? a : b;
        hi1 = (a < b) ? b : a;
        lo2 = (c < d) ? c : d;
        hi2 = (c < d) ? d : c;
        return !(hi1 < lo2) && !(hi2 < lo1);
    endfunction

    always_comb begin
        diff_next.qr_x = DIFF_BITS'(cfg.ray_end_x) - DIFF_BITS'(cfg.query_x);
        diff_next.qr_y = DIFF_BITS'(cfg.ray_end_y) - DIFF_BITS'(cfg.query_y);
        diff_next.qs_x = DIFF_BITS'(in_item.start_x) - DIFF_BITS'(cfg.query_x);
        diff_next.qs_y = DIFF_BITS'(in_item.start_y) - DIFF_BITS'(cfg.query_y);
        diff_next.qe_x = DIFF_BITS'(in_item.end_x) - DIFF_BITS'(cfg.query_x);
        diff_next.qe_y = DIFF_BITS'(in_item.end_y) - DIFF_BITS'(cfg.query_y);
        diff_next.se_x = DIFF_BITS'(in_item.end_x) - DIFF_BITS'(in_item.start_x);
        diff_next.se_y = DIFF_BITS'(in_item.end_y) - DIFF_BITS'(in_item.start_y);
        diff_next.sq_x = DIFF_BITS'(cfg.query_x) - DIFF_BITS'(in_item.start_x);
        diff_next.sq_y = DIFF_BITS'(cfg.query_y) - DIFF_BITS'(in_item.start_y);
        diff_next.sr_x = DIFF_BITS'(cfg.ray_end_x) - DIFF_BITS'(in_item.start_x);
        diff_next.sr_y = DIFF_BITS'(cfg.ray_end_y) - DIFF_BITS'(in_item.start_y);
        diff_next.box_ok =
            ranges_meet(cfg.query_x, cfg.ray_end_x, in_item.start_x, in_item.end_x) &&
            ranges_meet(cfg.query_y, cfg.ray_end_y, in_item.start_y, in_item.end_y);
        diff_next.last = in_item.last;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            diff_reg <= diff_next;
        end
    end

endmodule

@@ hw/rtl/pipc_cross.sv @@
module pipc_cross
    import pipc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  diff_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output hit_t  out_item
);

    logic  prod_valid_reg;
    prod_t prod_reg;
    prod_t prod_next;
    logic  prod_ready;

    logic  hit_valid_reg;
    hit_t  hit_reg;
    hit_t  hit_next;

    logic  pos_s, neg_s, pos_e, neg_e, pos_q, neg_q, pos_r, neg_r;

    // one multiplier per product, all in parallel
    always_comb begin
        prod_next.s_a    = PROD_BITS'(in_item.qr_x) * PROD_BITS'(in_item.qs_y);
        prod_next.s_b    = PROD_BITS'(in_item.qr_y) * PROD_BITS'(in_item.qs_x);
        prod_next.e_a    = PROD_BITS'(in_item.qr_x) * PROD_BITS'(in_item.qe_y);
        prod_next.e_b    = PROD_BITS'(in_item.qr_y) * PROD_BITS'(in_item.qe_x);
        prod_next.q_a    = PROD_BITS'(in_item.se_x) * PROD_BITS'(in_item.sq_y);
        prod_next.q_b    = PROD_BITS'(in_item.se_y) * PROD_BITS'(in_item.sq_x);
        prod_next.r_a    = PROD_BITS'(in_item.se_x) * PROD_BITS'(in_item.sr_y);
        prod_next.r_b    = PROD_BITS'(in_item.se_y) * PROD_BITS'(in_item.sr_x);
        prod_next.box_ok = in_item.box_ok;
        prod_next.last   = in_item.last;
    end

    // sign of a cross product from comparing its two terms
    always_comb begin
        pos_s = prod_reg.s_a > prod_reg.s_b;
        neg_s = prod_reg.s_a < prod_reg.s_b;
        pos_e = prod_reg.e_a > prod_reg.e_b;
        neg_e = prod_reg.e_a < prod_reg.e_b;
        pos_q = prod_reg.q_a > prod_reg.q_b;
        neg_q = prod_reg.q_a < prod_reg.q_b;
        pos_r = prod_reg.r_a > prod_reg.r_b;
        neg_r = prod_reg.r_a < prod_reg.r_b;
        hit_next.hit = prod_reg.box_ok &&
                       !((pos_s && pos_e) || (neg_s && neg_e)) &&
                       !((pos_q && pos_r) || (neg_q && neg_r));
        hit_next.last = prod_reg.last;
    end

    assign prod_ready = !hit_valid_reg || out_ready;
    assign in_ready   = !prod_valid_reg || prod_ready;
    assign out_valid  = hit_valid_reg;
    assign out_item   = hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            hit_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready) begin
                hit_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
        end
        if (prod_ready && prod_valid_reg) begin
            hit_reg <= hit_next;
        end
    end

endmodule

@@ hw/rtl/pipc_accum.sv @@
module pipc_accum
    import pipc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hit_t                  in_item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic                  res_inside,
    output logic [COUNT_BITS-1:0] res_crossings
);

    logic                  parity_reg;
    logic                  parity_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  res_valid_reg;
    logic                  inside_reg;
    logic [COUNT_BITS-1:0] crossings_reg;
    logic                  out_free;
    logic                  take;

    assign out_free = !res_valid_reg || res_ready;
    // a non-last edge never waits on the result register
    assign in_ready = !in_item.last || out_free;
    assign take     = in_valid && in_ready;

    always_comb begin
        parity_next = parity_reg ^ in_item.hit;
        count_next  = count_reg;
        if (in_item.hit && (count_reg != '1)) begin
            count_next = count_reg + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg    <= 1'b0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_valid_reg && res_ready) begin
                res_valid_reg <= 1'b0;
            end
            if (take) begin
                if (in_item.last) begin
                    res_valid_reg <= 1'b1;
                    parity_reg    <= 1'b0;
                    count_reg     <= '0;
                end else begin
                    parity_reg <= parity_next;
                    count_reg  <= count_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && in_item.last) begin
            inside_reg    <= parity_next;
            crossings_reg <= count_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign res_inside    = inside_reg;
    assign res_crossings = crossings_reg;

endmodule

@@ hw/rtl/point_in_polygon_crossing_test_unit.sv @@
// Ray-casting point-in-polygon test. Write the query point and the far end of the
// test ray through the cfg port, then stream the polygon's edges on s_, one edge per
// item, with s_tlast on the final edge. An edge counts as a crossing when its box
// and the ray's box overlap (touching included) and each segment's endpoints lie on
// opposite sides of, or on, the other segment's line. On the last edge one result
// appears on m_: the parity of the crossings (1 = inside) and the crossing count,
// which saturates at 65535; the counters then clear for the next polygon. Edges
// stream in at one per cycle unless a waiting result stalls them. A result reaches
// m_tdata after the last edge passes input register, coordinate differences,
// eight parallel 25x25 multipliers, product compare and result register. A waiting
// result stalls the input only when a later last edge reaches the accumulator.
module point_in_polygon_crossing_test_unit
    import pipc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // edge_start_x, edge_start_y, edge_end_x, edge_end_y
    input  logic [S_DATA_BITS-1:0]    s_tdata,
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // inside_res, crossings, zero fill
    output logic [M_DATA_BITS-1:0]    m_tdata
);

    cfg_t                  cfg_reg;
    logic                  in_valid_reg;
    edge_t                 edge_reg;
    logic                  prep_ready;
    logic                  diff_valid;
    logic                  diff_ready;
    diff_t                 diff_item;
    logic                  hit_valid;
    logic                  hit_ready;
    hit_t                  hit_item;
    logic                  res_inside;
    logic [COUNT_BITS-1:0] res_crossings;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.query_x   <= '0;
            cfg_reg.query_y   <= '0;
            cfg_reg.ray_end_x <= RAY_END_RESET;
            cfg_reg.ray_end_y <= RAY_END_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_QUERY_X:   cfg_reg.query_x   <= cfg_data;
                CFG_QUERY_Y:   cfg_reg.query_y   <= cfg_data;
                CFG_RAY_END_X: cfg_reg.ray_end_x <= cfg_data;
                CFG_RAY_END_Y: cfg_reg.ray_end_y <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = !in_valid_reg || prep_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            edge_reg.start_x <= s_tdata[0 * COORD_BITS +: COORD_BITS];
            edge_reg.start_y <= s_tdata[1 * COORD_BITS +: COORD_BITS];
            edge_reg.end_x   <= s_tdata[2 * COORD_BITS +: COORD_BITS];
            edge_reg.end_y   <= s_tdata[3 * COORD_BITS +: COORD_BITS];
            edge_reg.last    <= s_tlast;
        end
    end

    pipc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (in_valid_reg),
        .in_ready  (prep_ready),
        .in_item   (edge_reg),
        .out_valid (diff_valid),
        .out_ready (diff_ready),
        .out_item  (diff_item)
    );

    pipc_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (diff_valid),
        .in_ready  (diff_ready),
        .in_item   (diff_item),
        .out_valid (hit_valid),
        .out_ready (hit_ready),
        .out_item  (hit_item)
    );

    pipc_accum u_accum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (hit_valid),
        .in_ready      (hit_ready),
        .in_item       (hit_item),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res_inside    (res_inside),
        .res_crossings (res_crossings)
    );

    assign m_tdata = M_DATA_BITS'({res_crossings, res_inside});

    // below saturation the inside flag is the low bit of the count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (res_crossings != '1)) |-> (res_inside == res_crossings[0]))
        else $error("inside flag disagrees with crossing count");

    // a last edge taken by the accumulator always shows up as a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (hit_valid && hit_ready && hit_item.last) |=> m_tvalid)
        else $error("last edge produced no result");

    // a non-last edge is never held back by the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (hit_valid && !hit_item.last) |-> hit_ready)
        else $error("non-last edge stalled at accumulator");

endmodule
